/* src/adfs_pkg.sv */
package adfs_pkg;

   localparam int FRAME_BITS_DEF = 24;

   localparam logic [1:0] MODE_VOLT = 2'd0;
   localparam logic [1:0] MODE_CURR = 2'd1;

   localparam logic [3:0] CH_MIN = 4'd1;
   localparam logic [3:0] CH_MAX = 4'd8;
   localparam logic [3:0] CH_SPLIT = 4'd4;

   localparam logic [13:0] VOLT_CAP = 14'd9999;
   localparam logic [14:0] CURR_CAP = 15'd19999;
   localparam logic [14:0] CURR_ZERO = 15'd3984;
   localparam logic [9:0] CURR_MUL = 10'd1000;
   localparam logic [24:0] CURR_OFFSET = 25'd3984060;

   localparam logic [23:0] VOLT_DIV = 24'd10000;
   localparam logic [23:0] CURR_DIV = 24'd16095940;
   localparam logic [26:0] VOLT_RECIP = 27'd109951162;
   localparam logic [26:0] CURR_RECIP = 27'd68309;

   localparam logic [23:0] BASE_LOW = 24'h100000;
   localparam logic [23:0] BASE_HIGH = 24'h500000;
   localparam int SEL_SHIFT = 17;

   typedef struct packed {
      logic signed [15:0] setpoint_milli;
      logic [3:0] channel;
      logic [1:0] mode;
   } req_type;

   typedef struct packed {
      logic serial_bit;
      logic frame_start;
      logic last_bit;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* src/adfs_front.sv */
module adfs_front #(
   parameter int FRAME_BITS = adfs_pkg::FRAME_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  adfs_pkg::req_type req_data,
   output logic busy,
   input  adfs_pkg::q_stat_type q_stat,
   output logic push,
   output logic [FRAME_BITS-1:0] push_frame
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MUL = 3'd2;
   localparam logic [2:0] ST_FIX = 3'd3;
   localparam logic [2:0] ST_ADJ = 3'd4;
   localparam logic [2:0] ST_PUSH = 3'd5;

   logic [2:0] state_ff, state_in;
   adfs_pkg::req_type req_ff, req_in;
   logic [23:0] x_ff, x_in;
   logic [23:0] d_ff, d_in;
   logic [26:0] k_ff, k_in;
   logic [15:0] est_ff, est_in;
   logic [39:0] qd_ff, qd_in;
   logic [15:0] code_ff, code_in;
   logic [23:0] hdr_ff, hdr_in;

   logic [14:0] v;
   logic [13:0] vv;
   logic [14:0] vc;
   logic [24:0] prod;
   logic [24:0] num;
   logic [3:0] ch_m1;
   logic ch_ok;
   logic [50:0] mul;
   logic [39:0] rem;
   logic up;

   always_comb begin
      v = req_ff.setpoint_milli[15] ? 15'd0 : 15'(req_ff.setpoint_milli[14:0]);
      vv = (v > 15'(adfs_pkg::VOLT_CAP)) ? adfs_pkg::VOLT_CAP : v[13:0];
      vc = (v > adfs_pkg::CURR_CAP) ? adfs_pkg::CURR_CAP : v;
      prod = 25'(vc) * 25'(adfs_pkg::CURR_MUL);
      num = prod - adfs_pkg::CURR_OFFSET;
      ch_m1 = req_ff.channel - 4'd1;
      ch_ok = (req_ff.channel >= adfs_pkg::CH_MIN) && (req_ff.channel <= adfs_pkg::CH_MAX);
      mul = x_ff * k_ff;
      rem = {x_ff, 16'd0} - qd_ff;
      up = (rem >= {16'd0, d_ff});
   end

   // The reciprocal product can fall one short of the true quotient, and the
   // remainder check adds that step back.
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      x_in = x_ff;
      d_in = d_ff;
      k_in = k_ff;
      est_in = est_ff;
      qd_in = qd_ff;
      code_in = code_ff;
      hdr_in = hdr_ff;
      push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            hdr_in = ((req_ff.channel <= adfs_pkg::CH_SPLIT) ? adfs_pkg::BASE_LOW
                                                            : adfs_pkg::BASE_HIGH)
                     | (24'(ch_m1[1:0]) << adfs_pkg::SEL_SHIFT);
            if (req_ff.mode == adfs_pkg::MODE_VOLT) begin
               x_in = 24'(vv);
               d_in = adfs_pkg::VOLT_DIV;
               k_in = adfs_pkg::VOLT_RECIP;
            end else if (req_ff.mode == adfs_pkg::MODE_CURR && vc > adfs_pkg::CURR_ZERO) begin
               x_in = num[23:0];
               d_in = adfs_pkg::CURR_DIV;
               k_in = adfs_pkg::CURR_RECIP;
            end else begin
               x_in = '0;
               d_in = adfs_pkg::VOLT_DIV;
               k_in = adfs_pkg::VOLT_RECIP;
            end
            state_in = ch_ok ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            est_in = mul[39:24];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            qd_in = est_ff * d_ff;
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            code_in = est_ff + 16'(up);
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!q_stat.full) begin
               push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff <= req_in;
      x_ff <= x_in;
      d_ff <= d_in;
      k_ff <= k_in;
      est_ff <= est_in;
      qd_ff <= qd_in;
      code_ff <= code_in;
      hdr_ff <= hdr_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign push_frame = FRAME_BITS'(hdr_ff + {8'd0, code_ff});

`ifndef NO_ASSERTIONS
   a_push_after_div: assert property (@(posedge clock) disable iff (reset)
      push |-> $past(state_ff == ST_ADJ || state_ff == ST_PUSH))
      else $error("Frame pushed without a finished code.");
`endif

endmodule

/* src/adfs_queue.sv */
module adfs_queue #(
   parameter int FRAME_BITS = adfs_pkg::FRAME_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [FRAME_BITS-1:0] push_frame,
   input  logic pop,
   output logic [FRAME_BITS-1:0] pop_frame,
   output adfs_pkg::q_stat_type q_stat
);

   logic [FRAME_BITS-1:0] slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign pop_frame = slot_ff[rd_ptr_ff];
   assign q_stat.full = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("Transfer into a full queue.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("Read from an empty queue.");
`endif

endmodule

/* src/adfs_back.sv */
module adfs_back #(
   parameter int FRAME_BITS = adfs_pkg::FRAME_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  adfs_pkg::q_stat_type q_stat,
   input  logic [FRAME_BITS-1:0] pop_frame,
   output logic pop,
   output logic rsp_strobe,
   output adfs_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(FRAME_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_BITS - 1);

   logic active_ff, active_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0] sh_ff, sh_in;
   logic at_last;

   always_comb begin
      at_last = active_ff && (cnt_ff == LAST);
      pop = !q_stat.empty && (!active_ff || at_last);
      active_in = active_ff;
      cnt_in = cnt_ff + 1'b1;
      sh_in = {sh_ff[FRAME_BITS-2:0], 1'b0};
      if (pop) begin
         active_in = 1'b1;
         cnt_in = '0;
         sh_in = pop_frame;
      end else if (at_last) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff <= cnt_in;
      end
      sh_ff <= sh_in;
   end

   assign rsp_strobe = active_ff;
   assign rsp_data.serial_bit = sh_ff[FRAME_BITS-1];
   assign rsp_data.frame_start = active_ff && (cnt_ff == '0);
   assign rsp_data.last_bit = at_last;

`ifndef NO_ASSERTIONS
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_bit |=> !rsp_strobe || rsp_data.frame_start)
      else $error("Frame followed by a transfer that is not a frame start.");
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_bit |=> rsp_strobe && !rsp_data.frame_start)
      else $error("Frame cut short.");
`endif

endmodule

/* src/analog_out_dac_frame_serializer_core.sv */
// From a request transfer to the first frame bit on the result ports, when the queue is
// empty, the front steps through classify, reciprocal multiply, remainder, correction and
// enqueue, and then the shift register is loaded; an out-of-range channel yields no frame.
// Throughput: 24-bit frames go out one bit per cycle from the shift register;
// the front is busy until its frame is pushed; a two-entry queue holds frames meanwhile.
// The receiver cannot stall. Reset is synchronous and active high; it empties the queue.
module analog_out_dac_frame_serializer_core #(
   parameter int FRAME_BITS = adfs_pkg::FRAME_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  adfs_pkg::req_type req_data,
   output logic rsp_strobe,
   output adfs_pkg::rsp_type rsp_data
);

   adfs_pkg::q_stat_type q_stat;
   logic push;
   logic pop;
   logic [FRAME_BITS-1:0] push_frame;
   logic [FRAME_BITS-1:0] pop_frame;

   adfs_front #(.FRAME_BITS(FRAME_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .q_stat(q_stat),
      .push(push),
      .push_frame(push_frame)
   );

   adfs_queue #(.FRAME_BITS(FRAME_BITS)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_frame(push_frame),
      .pop(pop),
      .pop_frame(pop_frame),
      .q_stat(q_stat)
   );

   adfs_back #(.FRAME_BITS(FRAME_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .q_stat(q_stat),
      .pop_frame(pop_frame),
      .pop(pop),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

endmodule
